// File: sv/fifo_handle_pool_allocator_assert.svh
// Assertion macros for the handle pool allocator.
// Used by modules that have clk and arst_n in scope; depends on nothing else.
`ifndef FIFO_HANDLE_POOL_ALLOCATOR_ASSERT_SVH
`define FIFO_HANDLE_POOL_ALLOCATOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define FHPA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define FHPA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define FHPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fhpa_pkg.sv
// Shared types and constants for the handle pool allocator.
// Depends on nothing; the controller, datapath, top level and testbench refer to it by scoped names.
package fhpa_pkg;

	localparam int POOL_SIZE = 64;
	localparam int HANDLE_W  = 6;
	localparam int PTR_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_TRY   = 2'd1;
	localparam logic [1:0] FUNC_FREE  = 2'd2;

	localparam logic [2:0] ST_REUSED    = 3'd0;
	localparam logic [2:0] ST_FRESH     = 3'd1;
	localparam logic [2:0] ST_NONE      = 3'd2;
	localparam logic [2:0] ST_NOTALLOC  = 3'd3;
	localparam logic [2:0] ST_EXHAUSTED = 3'd4;

	typedef struct packed {
		logic [1:0]          func;
		logic [HANDLE_W-1:0] handle_in;
	} fhpa_req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [2:0]          status;
		logic [6:0]          free_count;
	} fhpa_result_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic exec;
	} fhpa_cmd_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_LOOKUP,
		FSM_EXEC
	} fhpa_state_t;

endpackage

// File: sv/fhpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fhpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/fhpa_ctrl.sv
// Controller state machine for the handle pool allocator.
// Depends on fhpa_pkg; drives the datapath through fhpa_cmd_t.
module fhpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output fhpa_pkg::fhpa_cmd_t cmd
);

	fhpa_pkg::fhpa_state_t state_q;
	fhpa_pkg::fhpa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhpa_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		cmd.load   = 1'b0;
		cmd.lookup = 1'b0;
		cmd.exec   = 1'b0;
		unique case (state_q)
			fhpa_pkg::FSM_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = fhpa_pkg::FSM_LOOKUP;
				end
			end
			fhpa_pkg::FSM_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = fhpa_pkg::FSM_EXEC;
			end
			fhpa_pkg::FSM_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = fhpa_pkg::FSM_IDLE;
			end
			default: begin
				state_d = fhpa_pkg::FSM_IDLE;
			end
		endcase
	end

endmodule

// File: sv/fhpa_datapath.sv
// Datapath of the handle pool allocator: queue pointers, allocation bitmap,
// fresh counter and result register. Depends on fhpa_pkg, fhpa_ram and the assert header.
`include "fifo_handle_pool_allocator_assert.svh"

module fhpa_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fhpa_pkg::fhpa_cmd_t    cmd,
	input  fhpa_pkg::fhpa_req_t    req,
	output logic                   done,
	output fhpa_pkg::fhpa_result_t result
);

	localparam int PtrW = fhpa_pkg::PTR_W;
	localparam int CntW = fhpa_pkg::CNT_W;
	localparam int HW   = fhpa_pkg::HANDLE_W;
	localparam logic [CntW-1:0] PoolCnt = CntW'(fhpa_pkg::POOL_SIZE);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(fhpa_pkg::POOL_SIZE - 1);

	fhpa_pkg::fhpa_req_t    req_q;
	fhpa_pkg::fhpa_result_t res_d;
	fhpa_pkg::fhpa_result_t result_q;
	logic                   done_q;

	logic [PtrW-1:0]               head_q, head_d;
	logic [PtrW-1:0]               tail_q, tail_d;
	logic [CntW-1:0]               count_q, count_d;
	logic [CntW-1:0]               fresh_q, fresh_d;
	logic [fhpa_pkg::POOL_SIZE-1:0] map_q, map_d;

	logic            ram_we;
	logic [HW-1:0]   ram_rdata;
	logic [HW-1:0]   hin_ext;

	fhpa_ram #(
		.WIDTH(HW),
		.DEPTH(fhpa_pkg::POOL_SIZE)
	) u_queue_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(req_q.handle_in),
		.re   (cmd.lookup),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign hin_ext = req_q.handle_in;

	// The head entry is read in the lookup cycle; the update happens in the execute cycle.
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		fresh_d = fresh_q;
		map_d   = map_q;
		ram_we  = 1'b0;
		res_d.handle_out = '0;
		res_d.status     = fhpa_pkg::ST_REUSED;
		case (req_q.func) inside
			fhpa_pkg::FUNC_ALLOC, fhpa_pkg::FUNC_TRY: begin
				if (count_q != '0) begin
					res_d.handle_out = ram_rdata;
					map_d[PtrW'(ram_rdata)] = 1'b1;
					head_d  = (head_q == LastPtr) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
				end else if (req_q.func == fhpa_pkg::FUNC_TRY) begin
					res_d.status = fhpa_pkg::ST_NONE;
				end else if (fresh_q >= PoolCnt) begin
					res_d.status = fhpa_pkg::ST_EXHAUSTED;
				end else begin
					res_d.handle_out = HW'(fresh_q);
					res_d.status     = fhpa_pkg::ST_FRESH;
					map_d[fresh_q[PtrW-1:0]] = 1'b1;
					fresh_d = fresh_q + 1'b1;
				end
			end
			fhpa_pkg::FUNC_FREE: begin
				if ((CntW'(hin_ext) < PoolCnt) && map_q[PtrW'(hin_ext)]) begin
					map_d[PtrW'(hin_ext)] = 1'b0;
					ram_we  = cmd.exec;
					tail_d  = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
					count_d = count_q + 1'b1;
				end else begin
					res_d.status = fhpa_pkg::ST_NOTALLOC;
				end
			end
			default: begin
			end
		endcase
		res_d.free_count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			map_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
				fresh_q <= fresh_d;
				map_q   <= map_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`FHPA_ASSERT_ALWAYS(a_count_le_issued, count_q <= fresh_q, "queue holds more handles than issued")
	`FHPA_ASSERT_ALWAYS(a_fresh_in_range, fresh_q <= PoolCnt, "fresh counter ran past the pool")
	`FHPA_ASSERT_SAME(a_ptrs_match, (count_q == '0) || (count_q == PoolCnt), head_q == tail_q, "queue pointers disagree with count")
	`FHPA_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe lasted more than one cycle")

endmodule

// File: sv/fifo_handle_pool_allocator.sv
// Top level of the handle pool allocator: controller plus datapath.
// Depends on fhpa_pkg, fhpa_ctrl and fhpa_datapath.
//
// Each accepted start runs a transaction through the lookup, execute and done cycles in order.
// The lookup cycle does the registered read of the free-queue RAM head entry. The execute
// cycle updates the queue, bitmap and fresh counter and registers the result. The done
// cycle shows the result with done high. busy is high in the lookup and execute cycles and
// low again in the done cycle, so a new request can be taken at the edge that ends it. The
// result sits on the result port for exactly one cycle with done high; the receiver cannot
// stall it and must take it then. No clearing pass is needed after reset: queue RAM data is
// used only from entries written since.
module fifo_handle_pool_allocator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  fhpa_pkg::fhpa_req_t    req,
	output logic                   done,
	output fhpa_pkg::fhpa_result_t result
);

	fhpa_pkg::fhpa_cmd_t cmd;

	fhpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	fhpa_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.done  (done),
		.result(result)
	);

endmodule

// File: sim/tb_fifo_handle_pool_allocator.sv
// Self-checking testbench for the handle pool allocator.
// It mirrors the free queue, allocation bitmap and fresh counter, then checks every result.
// Depends on fhpa_pkg and fifo_handle_pool_allocator.
module tb_fifo_handle_pool_allocator;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	fhpa_pkg::fhpa_req_t    req;
	logic                   done;
	fhpa_pkg::fhpa_result_t result;

	// Mirror of the allocator state, updated when a request is accepted.
	logic [fhpa_pkg::HANDLE_W-1:0] free_list[$];
	logic [fhpa_pkg::POOL_SIZE-1:0] held_map;
	int fresh_next;

	fhpa_pkg::fhpa_result_t due_results[$];
	int err_count;
	int cycle_count;
	int idle_pct;

	fifo_handle_pool_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fifo_handle_pool_allocator: mismatch");
			$finish;
		end
	end

	function automatic fhpa_pkg::fhpa_result_t apply_pool_op(input fhpa_pkg::fhpa_req_t r);
		fhpa_pkg::fhpa_result_t res;
		res = '0;
		res.status = fhpa_pkg::ST_REUSED;
		case (r.func)
			fhpa_pkg::FUNC_ALLOC, fhpa_pkg::FUNC_TRY: begin
				if (free_list.size() > 0) begin
					res.handle_out = free_list.pop_front();
					held_map[res.handle_out] = 1'b1;
				end else if (r.func == fhpa_pkg::FUNC_TRY) begin
					res.status = fhpa_pkg::ST_NONE;
				end else if (fresh_next >= fhpa_pkg::POOL_SIZE) begin
					res.status = fhpa_pkg::ST_EXHAUSTED;
				end else begin
					res.handle_out = fhpa_pkg::HANDLE_W'(fresh_next);
					held_map[fresh_next] = 1'b1;
					fresh_next++;
					res.status = fhpa_pkg::ST_FRESH;
				end
			end
			fhpa_pkg::FUNC_FREE: begin
				if (int'(r.handle_in) < fhpa_pkg::POOL_SIZE && held_map[r.handle_in]) begin
					held_map[r.handle_in] = 1'b0;
					free_list.push_back(r.handle_in);
				end else begin
					res.status = fhpa_pkg::ST_NOTALLOC;
				end
			end
			default: ;
		endcase
		res.free_count = 7'(free_list.size());
		return res;
	endfunction

	// Returns a handle that is held now, or a random one when none is held.
	function automatic logic [fhpa_pkg::HANDLE_W-1:0] pick_held();
		int n;
		int k;
		n = $countones(held_map);
		if (n == 0)
			return fhpa_pkg::HANDLE_W'($urandom);
		k = $urandom_range(n - 1);
		for (int i = 0; i < fhpa_pkg::POOL_SIZE; i++) begin
			if (held_map[i]) begin
				if (k == 0)
					return fhpa_pkg::HANDLE_W'(i);
				k--;
			end
		end
		return '0;
	endfunction

	// Drives one request and blocks until the allocator takes it.
	task automatic issue_op(input logic [1:0] f, input logic [fhpa_pkg::HANDLE_W-1:0] h);
		fhpa_pkg::fhpa_req_t r;
		int gap;
		r.func = f;
		r.handle_in = h;
		gap = 0;
		if (int'($urandom_range(99)) < idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			req <= fhpa_pkg::fhpa_req_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		due_results.push_back(apply_pool_op(r));
	endtask

	task automatic test_directed();
		issue_op(fhpa_pkg::FUNC_TRY, 6'd0);        // empty queue, nothing to reuse
		issue_op(fhpa_pkg::FUNC_FREE, 6'd0);       // release of a handle never issued
		issue_op(fhpa_pkg::FUNC_FREE, 6'd63);
		issue_op(FUNC_UNUSED, 6'd63);
		issue_op(fhpa_pkg::FUNC_ALLOC, 6'd63);     // fresh 0
		issue_op(fhpa_pkg::FUNC_ALLOC, 6'd0);      // fresh 1
		issue_op(fhpa_pkg::FUNC_ALLOC, 6'd21);     // fresh 2
		issue_op(fhpa_pkg::FUNC_FREE, 6'd0);
		issue_op(fhpa_pkg::FUNC_FREE, 6'd0);       // second release of the same handle
		issue_op(fhpa_pkg::FUNC_FREE, 6'd2);
		issue_op(fhpa_pkg::FUNC_FREE, 6'd42);
		issue_op(FUNC_UNUSED, 6'd0);
		issue_op(fhpa_pkg::FUNC_TRY, 6'd63);       // reuses 0, the oldest released
		issue_op(fhpa_pkg::FUNC_ALLOC, 6'd0);      // reuses 2
		issue_op(fhpa_pkg::FUNC_ALLOC, 6'd0);      // queue empty again, fresh 3
		issue_op(fhpa_pkg::FUNC_TRY, 6'd0);
		issue_op(fhpa_pkg::FUNC_FREE, 6'd1);
		issue_op(fhpa_pkg::FUNC_FREE, 6'd3);
		issue_op(fhpa_pkg::FUNC_FREE, 6'd63);
		issue_op(fhpa_pkg::FUNC_TRY, 6'd0);
	endtask

	task automatic test_random_traffic(input int count, input int sender_idle);
		idle_pct = sender_idle;
		repeat (count) begin
			int roll;
			roll = $urandom_range(99);
			if (roll < 40)
				issue_op(fhpa_pkg::FUNC_ALLOC, fhpa_pkg::HANDLE_W'($urandom));
			else if (roll < 52)
				issue_op(fhpa_pkg::FUNC_TRY, fhpa_pkg::HANDLE_W'($urandom));
			else if (roll < 88)
				issue_op(fhpa_pkg::FUNC_FREE, pick_held());
			else if (roll < 96)
				issue_op(fhpa_pkg::FUNC_FREE, fhpa_pkg::HANDLE_W'($urandom));
			else
				issue_op(FUNC_UNUSED, fhpa_pkg::HANDLE_W'($urandom));
		end
	endtask

	// Issues every handle, runs into exhaustion, fills the free queue to the whole pool
	// and drains it again.
	task automatic test_pool_exhaustion();
		while (free_list.size() > 0 || fresh_next < fhpa_pkg::POOL_SIZE)
			issue_op(fhpa_pkg::FUNC_ALLOC, fhpa_pkg::HANDLE_W'($urandom));
		issue_op(fhpa_pkg::FUNC_ALLOC, fhpa_pkg::HANDLE_W'($urandom));
		issue_op(fhpa_pkg::FUNC_TRY, fhpa_pkg::HANDLE_W'($urandom));
		while (held_map != '0)
			issue_op(fhpa_pkg::FUNC_FREE, pick_held());
		issue_op(fhpa_pkg::FUNC_FREE, fhpa_pkg::HANDLE_W'($urandom));
		while (free_list.size() > 0)
			issue_op(fhpa_pkg::FUNC_TRY, fhpa_pkg::HANDLE_W'($urandom));
		issue_op(fhpa_pkg::FUNC_ALLOC, fhpa_pkg::HANDLE_W'($urandom));
		issue_op(fhpa_pkg::FUNC_TRY, fhpa_pkg::HANDLE_W'($urandom));
	endtask

	always @(posedge clk) begin : check_results
		fhpa_pkg::fhpa_result_t want;
		if (arst_n && done === 1'b1) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, %s %0d %0d %0d",
					$time, "got handle_out status free_count",
					result.handle_out, result.status, result.free_count);
				err_count++;
			end else begin
				want = due_results.pop_front();
				if (result.handle_out !== want.handle_out) begin
					$display("%0t: handle_out expected %0d, got %0d",
						$time, want.handle_out, result.handle_out);
					err_count++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, result.status);
					err_count++;
				end
				if (result.free_count !== want.free_count) begin
					$display("%0t: free_count expected %0d, got %0d",
						$time, want.free_count, result.free_count);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		held_map = '0;
		fresh_next = 0;
		err_count = 0;
		cycle_count = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(200, 20);
		test_pool_exhaustion();
		test_random_traffic(190, 46);
		test_random_traffic(190, 0);

		@(negedge clk);
		start <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("fifo_handle_pool_allocator: match");
		else
			$display("fifo_handle_pool_allocator: mismatch");
		$finish;
	end

endmodule
